FILE: sv/v4n_pkg.sv
// Shared types and constants for the four-component vector normalizer.
`timescale 1ns / 1ps
`default_nettype none
package v4n_pkg;

    localparam int unsigned COMP_W     = 32;
    localparam int unsigned LANES      = 4;
    localparam int unsigned SUM_W      = 64;
    localparam int unsigned ROOT_W     = 32;
    localparam int unsigned LEN_W      = 33;
    localparam int unsigned QUOT_W     = 31;
    localparam int unsigned SQRT_STEPS = ROOT_W;
    localparam int unsigned DIV_STEPS  = QUOT_W;
    localparam int unsigned EPS_W      = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    // Per-lane sign and magnitude, carried alongside the length computation
    typedef struct packed {
        logic [LANES-1:0]             sgn;
        logic [LANES-1:0][COMP_W-1:0] mag;
    } lanes_t;

    typedef logic [LANES-1:0][COMP_W-1:0] comp_vec_t;

endpackage
`default_nettype wire

FILE: sv/v4n_square_sum.sv
// Magnitude, square and sum stages producing the squared length.
`timescale 1ns / 1ps
`default_nettype none
module v4n_square_sum (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire v4n_pkg::comp_vec_t        comp,
    output logic                           out_valid,
    output v4n_pkg::lanes_t                out_lanes,
    output logic [v4n_pkg::SUM_W-1:0]      out_sum,
    output logic                           out_big
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    v4n_pkg::lanes_t lanes_next, lanes1_reg, lanes2_reg, lanes3_reg, lanes4_reg;
    logic [v4n_pkg::LANES-1:0][v4n_pkg::SUM_W-1:0] sq_reg;
    logic [v4n_pkg::SUM_W-1:0] s01_reg, s23_reg, sum_reg;
    logic [v4n_pkg::SUM_W:0]   total;
    logic big_reg;

    // Split each component into sign and magnitude
    always_comb
    begin
        for (int i = 0; i < int'(v4n_pkg::LANES); i++)
        begin
            lanes_next.sgn[i] = comp[i][v4n_pkg::COMP_W-1];
            lanes_next.mag[i] = comp[i][v4n_pkg::COMP_W-1] ? (~comp[i] + 1'b1) : comp[i];
        end
    end

    assign total = {1'b0, s01_reg} + {1'b0, s23_reg};

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance payload: square, pairwise add, final add
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lanes1_reg <= lanes_next;
            lanes2_reg <= lanes1_reg;
            lanes3_reg <= lanes2_reg;
            lanes4_reg <= lanes3_reg;
            for (int i = 0; i < int'(v4n_pkg::LANES); i++)
            begin
                sq_reg[i] <= lanes1_reg.mag[i] * lanes1_reg.mag[i];
            end
            s01_reg <= sq_reg[0] + sq_reg[1];
            s23_reg <= sq_reg[2] + sq_reg[3];
            sum_reg <= total[v4n_pkg::SUM_W-1:0];
            big_reg <= total[v4n_pkg::SUM_W];
        end
    end

    assign out_valid = v4_reg;
    assign out_lanes = lanes4_reg;
    assign out_sum   = sum_reg;
    assign out_big   = big_reg;

endmodule
`default_nettype wire

FILE: sv/v4n_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module v4n_sqrt (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire v4n_pkg::lanes_t           in_lanes,
    input  wire logic [v4n_pkg::SUM_W-1:0] in_sum,
    input  wire logic                      in_big,
    output logic                           out_valid,
    output v4n_pkg::lanes_t                out_lanes,
    output logic [v4n_pkg::LEN_W-1:0]      out_len
);

    localparam int unsigned N   = v4n_pkg::SQRT_STEPS;
    localparam int unsigned RW  = v4n_pkg::ROOT_W + 2;
    localparam int unsigned CW  = RW + 2;

    logic                           val_reg   [0:N-1];
    logic                           big_reg   [0:N-1];
    v4n_pkg::lanes_t                lanes_reg [0:N-1];
    logic [RW-1:0]                  rem_reg   [0:N-1];
    logic [v4n_pkg::ROOT_W-1:0]     root_reg  [0:N-1];
    logic [v4n_pkg::SUM_W-1:0]      vr_reg    [0:N-1];

    for (genvar k = 0; k < int'(N); k++)
    begin : g_step
        logic                       src_val, src_big;
        v4n_pkg::lanes_t            src_lanes;
        logic [RW-1:0]              src_rem;
        logic [v4n_pkg::ROOT_W-1:0] src_root;
        logic [v4n_pkg::SUM_W-1:0]  src_vr;
        logic [CW-1:0]              cur, trial, diff;
        logic                       ge;

        if (k == 0)
        begin : g_first
            assign src_val   = in_valid;
            assign src_big   = in_big;
            assign src_lanes = in_lanes;
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_vr    = in_sum;
        end
        else
        begin : g_next
            assign src_val   = val_reg[k-1];
            assign src_big   = big_reg[k-1];
            assign src_lanes = lanes_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_root  = root_reg[k-1];
            assign src_vr    = vr_reg[k-1];
        end

        // Bring down two bits and try the next root bit
        assign cur   = {src_rem, src_vr[v4n_pkg::SUM_W-1 -: 2]};
        assign trial = {2'b00, src_root, 2'b01};
        assign ge    = (cur >= trial);
        assign diff  = ge ? (cur - trial) : cur;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                val_reg[k] <= src_val;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                big_reg[k]   <= src_big;
                lanes_reg[k] <= src_lanes;
                rem_reg[k]   <= diff[RW-1:0];
                root_reg[k]  <= {src_root[v4n_pkg::ROOT_W-2:0], ge};
                vr_reg[k]    <= {src_vr[v4n_pkg::SUM_W-3:0], 2'b00};
            end
        end
    end

    // A squared length of two to the 64th has root two to the 32nd
    assign out_valid = val_reg[N-1];
    assign out_lanes = lanes_reg[N-1];
    assign out_len   = big_reg[N-1] ? {1'b1, {v4n_pkg::ROOT_W{1'b0}}}
                                    : {1'b0, root_reg[N-1]};

endmodule
`default_nettype wire

FILE: sv/v4n_divide.sv
// Zero test and pipelined restoring division of each component by the length.
`timescale 1ns / 1ps
`default_nettype none
module v4n_divide (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic [v4n_pkg::EPS_W-1:0] eps,
    input  wire logic                      in_valid,
    input  wire v4n_pkg::lanes_t           in_lanes,
    input  wire logic [v4n_pkg::LEN_W-1:0] in_len,
    output logic                           out_valid,
    output v4n_pkg::comp_vec_t             out_unit,
    output logic [v4n_pkg::LEN_W-1:0]      out_len,
    output logic                           out_zero
);

    localparam int unsigned N  = v4n_pkg::DIV_STEPS;
    localparam int unsigned L  = v4n_pkg::LANES;
    localparam int unsigned QW = v4n_pkg::QUOT_W;
    localparam int unsigned DW = v4n_pkg::LEN_W + 1;

    // Entry stage: length, zero flag, partial remainders
    logic                           e_val_reg;
    logic [v4n_pkg::LEN_W-1:0]      e_len_reg;
    logic                           e_zero_reg;
    logic [L-1:0]                   e_sgn_reg;
    logic [L-1:0][DW-1:0]           e_rem_reg;

    logic                           val_reg  [0:N-1];
    logic [v4n_pkg::LEN_W-1:0]      len_reg  [0:N-1];
    logic                           zero_reg [0:N-1];
    logic [L-1:0]                   sgn_reg  [0:N-1];
    logic [L-1:0][DW-1:0]           rem_reg  [0:N-1];
    logic [L-1:0][QW-1:0]           quo_reg  [0:N-1];

    logic                           o_val_reg, o_zero_reg;
    logic [v4n_pkg::LEN_W-1:0]      o_len_reg;
    v4n_pkg::comp_vec_t             o_unit_reg, unit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_val_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_val_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_len_reg  <= in_len;
            e_zero_reg <= (in_len <= {{(v4n_pkg::LEN_W-v4n_pkg::EPS_W){1'b0}}, eps});
            e_sgn_reg  <= in_lanes.sgn;
            for (int i = 0; i < int'(L); i++)
            begin
                e_rem_reg[i] <= {2'b00, in_lanes.mag[i]};
            end
        end
    end

    for (genvar k = 0; k < int'(N); k++)
    begin : g_step
        logic                       src_val, src_zero;
        logic [v4n_pkg::LEN_W-1:0]  src_len;
        logic [L-1:0]               src_sgn;
        logic [L-1:0][DW-1:0]       src_rem, rem_next;
        logic [L-1:0][QW-1:0]       src_quo, quo_next;

        if (k == 0)
        begin : g_first
            assign src_val  = e_val_reg;
            assign src_zero = e_zero_reg;
            assign src_len  = e_len_reg;
            assign src_sgn  = e_sgn_reg;
            assign src_rem  = e_rem_reg;
            assign src_quo  = '0;
        end
        else
        begin : g_next
            assign src_val  = val_reg[k-1];
            assign src_zero = zero_reg[k-1];
            assign src_len  = len_reg[k-1];
            assign src_sgn  = sgn_reg[k-1];
            assign src_rem  = rem_reg[k-1];
            assign src_quo  = quo_reg[k-1];
        end

        // Subtract the length where it fits, then shift for the next bit
        always_comb
        begin
            logic [DW-1:0] diff;
            logic          ge;
            for (int i = 0; i < int'(L); i++)
            begin
                ge          = (src_rem[i] >= {1'b0, src_len});
                diff        = ge ? (src_rem[i] - {1'b0, src_len}) : src_rem[i];
                rem_next[i] = {diff[DW-2:0], 1'b0};
                quo_next[i] = {src_quo[i][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                val_reg[k] <= src_val;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                zero_reg[k] <= src_zero;
                len_reg[k]  <= src_len;
                sgn_reg[k]  <= src_sgn;
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
            end
        end
    end

    // Apply sign, force zero vectors to zero
    always_comb
    begin
        for (int i = 0; i < int'(L); i++)
        begin
            if (zero_reg[N-1])
            begin
                unit_next[i] = '0;
            end
            else if (sgn_reg[N-1][i])
            begin
                unit_next[i] = ~{1'b0, quo_reg[N-1][i]} + 1'b1;
            end
            else
            begin
                unit_next[i] = {1'b0, quo_reg[N-1][i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_val_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_val_reg <= val_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_unit_reg <= unit_next;
            o_len_reg  <= len_reg[N-1];
            o_zero_reg <= zero_reg[N-1];
        end
    end

    assign out_valid = o_val_reg;
    assign out_unit  = o_unit_reg;
    assign out_len   = o_len_reg;
    assign out_zero  = o_zero_reg;

endmodule
`default_nettype wire

FILE: sv/vec4_normalize.sv
// Top level of the four-component vector normalizer.
//
// Input channel: in_valid/in_ready carry comp_x..comp_w, signed Q16.16.
// Output channel: out_valid/out_ready carry unit_x..unit_w (signed Q2.30),
// norm_len (floor of the Euclidean length, Q17.16) and was_zero.
// Configuration: cfg_we writes cfg_wdata into zero_epsilon; a length at or
// below it gives all-zero unit components and was_zero set.
//
// From input transfer to output valid, a vector passes the magnitude,
// square, pairwise-add and sum registers, 32 square-root stages (one root
// bit each), one zero-test stage, 31 division stages (one quotient bit
// each, four lanes side by side) and the output register.
// One vector per cycle except in a stall; the pipe advances as a whole.
// When the receiver stalls with a result waiting, every stage holds and
// in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets zero_epsilon to 1.
`timescale 1ns / 1ps
`default_nettype none
module vec4_normalize (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [v4n_pkg::EPS_W-1:0]    cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [31:0]           comp_x,
    input  wire logic signed [31:0]           comp_y,
    input  wire logic signed [31:0]           comp_z,
    input  wire logic signed [31:0]           comp_w,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [31:0]                unit_x,
    output logic signed [31:0]                unit_y,
    output logic signed [31:0]                unit_z,
    output logic signed [31:0]                unit_w,
    output logic [v4n_pkg::LEN_W-1:0]         norm_len,
    output logic                              was_zero
);

    logic [v4n_pkg::EPS_W-1:0] eps_reg;
    logic                      adv;
    v4n_pkg::comp_vec_t        comp, unit;
    logic                      sq_valid, rt_valid;
    v4n_pkg::lanes_t           sq_lanes, rt_lanes;
    logic [v4n_pkg::SUM_W-1:0] sq_sum;
    logic                      sq_big;
    logic [v4n_pkg::LEN_W-1:0] rt_len;

    // Hold the epsilon register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= v4n_pkg::EPS_RESET;
        end
        else if (cfg_we)
        begin
            eps_reg <= cfg_wdata;
        end
    end

    // Advance the pipe unless a result waits for transfer
    assign adv      = out_ready || !out_valid;
    assign in_ready = adv;

    assign comp = {comp_w, comp_z, comp_y, comp_x};

    v4n_square_sum u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .comp      (comp),
        .out_valid (sq_valid),
        .out_lanes (sq_lanes),
        .out_sum   (sq_sum),
        .out_big   (sq_big)
    );

    v4n_sqrt u_rt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_lanes  (sq_lanes),
        .in_sum    (sq_sum),
        .in_big    (sq_big),
        .out_valid (rt_valid),
        .out_lanes (rt_lanes),
        .out_len   (rt_len)
    );

    v4n_divide u_dv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .eps       (eps_reg),
        .in_valid  (rt_valid),
        .in_lanes  (rt_lanes),
        .in_len    (rt_len),
        .out_valid (out_valid),
        .out_unit  (unit),
        .out_len   (norm_len),
        .out_zero  (was_zero)
    );

    assign unit_x = unit[0];
    assign unit_y = unit[1];
    assign unit_z = unit[2];
    assign unit_w = unit[3];

endmodule
`default_nettype wire

FILE: sv/vec4_normalize_checker.sv
// Port-level checker for the vector normalizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vec4_normalize_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic signed [31:0]        unit_x,
    input wire logic signed [31:0]        unit_y,
    input wire logic signed [31:0]        unit_z,
    input wire logic signed [31:0]        unit_w,
    input wire logic [v4n_pkg::LEN_W-1:0] norm_len,
    input wire logic                      was_zero
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(norm_len))
        else $error("stalled result changed");

    // Zero vectors give zero components
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_zero |-> unit_x == 0 && unit_y == 0 && unit_z == 0 && unit_w == 0)
        else $error("zero vector with nonzero component");

    // unit_x and unit_w stay within unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x <= 32'sd1073741824 && unit_x >= -32'sd1073741824
                   && unit_w <= 32'sd1073741824 && unit_w >= -32'sd1073741824)
        else $error("component out of range");

    // Length never exceeds two to the 32nd
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> norm_len <= 33'h1_0000_0000)
        else $error("length out of range");

endmodule

bind vec4_normalize vec4_normalize_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .unit_x     (unit_x),
    .unit_y     (unit_y),
    .unit_z     (unit_z),
    .unit_w     (unit_w),
    .norm_len   (norm_len),
    .was_zero   (was_zero)
);
`default_nettype wire
